// ===== sv/cpde_pkg.sv =====
package cpde_pkg;

  // Word length of one message
  localparam int BITS_PER_WORD_DEF = 8;

  // Input command codes
  localparam logic [1:0] CMD_TICK   = 2'd0;
  localparam logic [1:0] CMD_SEND   = 2'd1;
  localparam logic [1:0] CMD_WAKEUP = 2'd2;

  // Request kinds after classification
  localparam logic [1:0] KIND_TICK   = 2'd0;
  localparam logic [1:0] KIND_SEND   = 2'd1;
  localparam logic [1:0] KIND_WAKEUP = 2'd2;

  // Configuration register indexes
  localparam logic [2:0] REG_PERIOD_HIGH = 3'd0;
  localparam logic [2:0] REG_PERIOD_LOW  = 3'd1;
  localparam logic [2:0] REG_PREAMBLE    = 3'd2;
  localparam logic [2:0] REG_ONE_GAP     = 3'd3;
  localparam logic [2:0] REG_ZERO_GAP    = 3'd4;
  localparam logic [2:0] REG_MARK        = 3'd5;
  localparam logic [2:0] REG_WAKE_REPS   = 3'd6;
  localparam logic [2:0] REG_WAKE_BYTE   = 3'd7;

  // Register reset values
  localparam logic [3:0] RST_PERIOD_HIGH = 4'd1;
  localparam logic [3:0] RST_PERIOD_LOW  = 4'd2;
  localparam logic [7:0] RST_PREAMBLE    = 8'd152;
  localparam logic [7:0] RST_ONE_GAP     = 8'd36;
  localparam logic [7:0] RST_ZERO_GAP    = 8'd12;
  localparam logic [7:0] RST_MARK        = 8'd12;
  localparam logic [5:0] RST_WAKE_REPS   = 6'd30;
  localparam logic [7:0] RST_WAKE_BYTE   = 8'hAA;

  typedef struct packed {
    logic [3:0] period_high_ticks;
    logic [3:0] period_low_ticks;
    logic [7:0] preamble_periods;
    logic [7:0] one_gap_periods;
    logic [7:0] zero_gap_periods;
    logic [7:0] mark_periods;
    logic [5:0] wakeup_repeats;
    logic [7:0] wakeup_byte;
  } cpde_cfg_t;

  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] data_byte;
  } cpde_req_t;

endpackage

// ===== sv/cpde_front.sv =====
module cpde_front
  import cpde_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [1:0] in_cmd,
  input  logic [7:0] in_data_byte,
  output logic       req_valid,
  input  logic       req_ready,
  output cpde_req_t  req
);

  cpde_req_t  entry_r [2];
  logic       wr_ptr_r, wr_ptr_nxt;
  logic       rd_ptr_r, rd_ptr_nxt;
  logic [1:0] count_r, count_nxt;
  logic       push, pop;
  cpde_req_t  classified;

  // Unknown command codes behave as a plain tick
  always_comb begin
    classified.data_byte = in_data_byte;
    unique case (in_cmd)
      CMD_SEND:   classified.kind = KIND_SEND;
      CMD_WAKEUP: classified.kind = KIND_WAKEUP;
      default:    classified.kind = KIND_TICK;
    endcase
  end

  assign in_ready  = (count_r != 2'd2);
  assign req_valid = (count_r != 2'd0);
  assign req       = entry_r[rd_ptr_r];
  assign push      = in_valid && in_ready;
  assign pop       = req_valid && req_ready;

  always_comb begin
    wr_ptr_nxt = push ? ~wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = pop ? ~rd_ptr_r : rd_ptr_r;
    count_nxt  = count_r + {1'b0, push} - {1'b0, pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entry_r[wr_ptr_r] <= classified;
    end
  end

endmodule

// ===== sv/cpde_back.sv =====
module cpde_back
  import cpde_pkg::*;
#(
  parameter int BITS_PER_WORD = BITS_PER_WORD_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  input  cpde_cfg_t cfg,
  input  logic      req_valid,
  output logic      req_ready,
  input  cpde_req_t req,
  output logic      out_valid,
  input  logic      out_ready,
  output logic      out_carrier_out,
  output logic      out_busy_res,
  output logic      out_rejected
);

  localparam int BLW = $clog2(BITS_PER_WORD + 1);

  localparam logic [1:0] PH_IDLE     = 2'd0;
  localparam logic [1:0] PH_PREAMBLE = 2'd1;
  localparam logic [1:0] PH_GAP      = 2'd2;
  localparam logic [1:0] PH_MARK     = 2'd3;

  logic [1:0]               phase_r, phase_nxt;
  logic [BITS_PER_WORD-1:0] shift_r, shift_nxt;
  logic [BLW-1:0]           bits_r, bits_nxt;
  logic [7:0]               pc_r, pc_nxt;
  logic [4:0]               tip_r, tip_nxt;
  logic [5:0]               rep_r, rep_nxt;

  logic                     out_valid_r, out_valid_nxt;
  logic                     carrier_r, busy_r, rej_r;

  logic                     fire;
  logic                     carrier, busy, rej;
  logic [1:0]               e_phase;
  logic [BITS_PER_WORD-1:0] e_shift;
  logic [BLW-1:0]           e_bits;
  logic [7:0]               e_pc;
  logic [4:0]               e_tip;
  logic [5:0]               e_rep;
  logic [4:0]               len;
  logic [4:0]               tip_inc;
  logic [8:0]               pc_inc;
  logic [7:0]               target;
  logic [BLW-1:0]           bits_dec;

  // Take a request whenever the output register is free or being drained
  assign req_ready = !out_valid_r || out_ready;
  assign fire      = req_valid && req_ready;

  always_comb begin
    rej     = 1'b0;
    carrier = 1'b0;
    busy    = 1'b0;
    e_phase = phase_r;
    e_shift = shift_r;
    e_bits  = bits_r;
    e_pc    = pc_r;
    e_tip   = tip_r;
    e_rep   = rep_r;
    len     = {1'b0, cfg.period_high_ticks} + {1'b0, cfg.period_low_ticks};
    tip_inc = 5'd0;
    pc_inc  = 9'd0;
    target  = 8'd0;
    bits_dec = '0;

    // Apply the command first: a fresh message starts on this very tick
    if (fire && req.kind != KIND_TICK) begin
      if (phase_r != PH_IDLE) begin
        rej = 1'b1;
      end else begin
        e_phase = PH_PREAMBLE;
        e_bits  = BLW'(BITS_PER_WORD);
        e_pc    = 8'd0;
        e_tip   = 5'd0;
        if (req.kind == KIND_SEND) begin
          e_rep   = 6'd1;
          e_shift = BITS_PER_WORD'(req.data_byte);
        end else begin
          e_rep   = (cfg.wakeup_repeats == 6'd0) ? 6'd1 : cfg.wakeup_repeats;
          e_shift = BITS_PER_WORD'(cfg.wakeup_byte);
        end
      end
    end

    phase_nxt = e_phase;
    shift_nxt = e_shift;
    bits_nxt  = e_bits;
    pc_nxt    = e_pc;
    tip_nxt   = e_tip;
    rep_nxt   = e_rep;

    if (fire && e_phase != PH_IDLE) begin
      busy = 1'b1;
      unique case (e_phase)
        PH_PREAMBLE: target = cfg.preamble_periods;
        PH_MARK:     target = cfg.mark_periods;
        default:     target = e_shift[BITS_PER_WORD-1] ? cfg.one_gap_periods
                                                       : cfg.zero_gap_periods;
      endcase
      carrier = (e_phase == PH_PREAMBLE || e_phase == PH_MARK) &&
                (e_tip < {1'b0, cfg.period_high_ticks});
      tip_inc = e_tip + 5'd1;
      pc_inc  = {1'b0, e_pc} + 9'd1;
      bits_dec = (e_bits != '0) ? e_bits - BLW'(1) : '0;
      if (tip_inc >= len) begin
        tip_nxt = 5'd0;
        if (pc_inc >= {1'b0, target}) begin
          pc_nxt = 8'd0;
          priority case (e_phase)
            PH_PREAMBLE: phase_nxt = PH_GAP;
            PH_GAP:      phase_nxt = PH_MARK;
            default: begin
              // End of a bit: advance the word, then next bit, next message or idle
              bits_nxt = bits_dec;
              if (bits_dec != '0) begin
                shift_nxt = e_shift << 1;
                phase_nxt = PH_GAP;
              end else if (e_rep > 6'd1) begin
                rep_nxt   = e_rep - 6'd1;
                phase_nxt = PH_PREAMBLE;
                shift_nxt = BITS_PER_WORD'(cfg.wakeup_byte);
                bits_nxt  = BLW'(BITS_PER_WORD);
              end else begin
                shift_nxt = e_shift << 1;
                rep_nxt   = 6'd0;
                phase_nxt = PH_IDLE;
              end
            end
          endcase
        end else begin
          pc_nxt = pc_inc[7:0];
        end
      end else begin
        tip_nxt = tip_inc;
      end
    end

    out_valid_nxt = fire ? 1'b1 : (out_ready ? 1'b0 : out_valid_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= PH_IDLE;
      shift_r     <= '0;
      bits_r      <= '0;
      pc_r        <= 8'd0;
      tip_r       <= 5'd0;
      rep_r       <= 6'd0;
      out_valid_r <= 1'b0;
    end else begin
      phase_r     <= phase_nxt;
      shift_r     <= shift_nxt;
      bits_r      <= bits_nxt;
      pc_r        <= pc_nxt;
      tip_r       <= tip_nxt;
      rep_r       <= rep_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      carrier_r <= carrier;
      busy_r    <= busy;
      rej_r     <= rej;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_carrier_out = carrier_r;
  assign out_busy_res    = busy_r;
  assign out_rejected    = rej_r;

endmodule

// ===== sv/carrier_pulse_distance_encoder_core.sv =====
// Channel  | Handshake              | Payload
// ---------+------------------------+--------------------------------------------
// in       | in_valid / in_ready    | in_cmd[1:0], in_data_byte[7:0]
// out      | out_valid / out_ready  | out_carrier_out, out_busy_res, out_rejected
// cfg      | cfg_valid / cfg_ready  | cfg_index[2:0], cfg_wdata[7:0]
//
// One request per clock while out_ready is high: the tick sequencer in the back end
// retires one request each cycle and the two-entry request queue keeps the input
// flowing. A taken request waits in the request queue, then its result is registered
// in the output register, where out_valid rises and holds until out_ready takes it.
// Reset (rst_n low, synchronous) empties the queue, idles the sequencer and loads
// the register defaults. cfg_ready is always high.
// A stalled output holds its result; the queue then fills and in_ready drops.
module carrier_pulse_distance_encoder_core
  import cpde_pkg::*;
#(
  parameter int BITS_PER_WORD = BITS_PER_WORD_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [1:0] in_cmd,
  input  logic [7:0] in_data_byte,
  output logic       out_valid,
  input  logic       out_ready,
  output logic       out_carrier_out,
  output logic       out_busy_res,
  output logic       out_rejected,
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic [2:0] cfg_index,
  input  logic [7:0] cfg_wdata
);

  cpde_cfg_t cfg_r, cfg_nxt;
  cpde_req_t req;
  logic      req_valid, req_ready;

  assign cfg_ready = 1'b1;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_valid) begin
      unique case (cfg_index)
        REG_PERIOD_HIGH: cfg_nxt.period_high_ticks = cfg_wdata[3:0];
        REG_PERIOD_LOW:  cfg_nxt.period_low_ticks  = cfg_wdata[3:0];
        REG_PREAMBLE:    cfg_nxt.preamble_periods  = cfg_wdata;
        REG_ONE_GAP:     cfg_nxt.one_gap_periods   = cfg_wdata;
        REG_ZERO_GAP:    cfg_nxt.zero_gap_periods  = cfg_wdata;
        REG_MARK:        cfg_nxt.mark_periods      = cfg_wdata;
        REG_WAKE_REPS:   cfg_nxt.wakeup_repeats    = cfg_wdata[5:0];
        REG_WAKE_BYTE:   cfg_nxt.wakeup_byte       = cfg_wdata;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.period_high_ticks <= RST_PERIOD_HIGH;
      cfg_r.period_low_ticks  <= RST_PERIOD_LOW;
      cfg_r.preamble_periods  <= RST_PREAMBLE;
      cfg_r.one_gap_periods   <= RST_ONE_GAP;
      cfg_r.zero_gap_periods  <= RST_ZERO_GAP;
      cfg_r.mark_periods      <= RST_MARK;
      cfg_r.wakeup_repeats    <= RST_WAKE_REPS;
      cfg_r.wakeup_byte       <= RST_WAKE_BYTE;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  cpde_front u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_cmd       (in_cmd),
    .in_data_byte (in_data_byte),
    .req_valid    (req_valid),
    .req_ready    (req_ready),
    .req          (req)
  );

  cpde_back #(
    .BITS_PER_WORD (BITS_PER_WORD)
  ) u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg             (cfg_r),
    .req_valid       (req_valid),
    .req_ready       (req_ready),
    .req             (req),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_carrier_out (out_carrier_out),
    .out_busy_res    (out_busy_res),
    .out_rejected    (out_rejected)
  );

endmodule
